[design/sdps_pkg.sv]
// ============================================================================
// sdps_pkg
// Shared types, register codes and fp32/fp16 helper functions.
// ============================================================================
`default_nettype none

package sdps_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_BETA  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_HALF  = CFG_INDEX_W'(2);

    localparam logic [31:0] ALPHA_RESET   = 32'h3F80_0000;
    localparam logic [31:0] FP_ZERO       = 32'h0000_0000;
    localparam logic [31:0] FP_NAN_INVAL  = 32'hFFC0_0000;
    localparam logic [31:0] FP_QUIET_BIT  = 32'h0040_0000;
    localparam logic [14:0] HALF_MAX_MAG  = 15'h7BFF;
    localparam logic [14:0] HALF_QNAN_MAG = 15'h7E00;
    localparam logic [14:0] HALF_INF_MAG  = 15'h7C00;

    typedef enum logic [0:0] {
        FP_MUL,
        FP_ADD
    } fp_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_XY,
        ST_ADD_ACC,
        ST_MUL_ALPHA,
        ST_MUL_BETA,
        ST_ADD_C,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] old;
        logic        last;
        logic        half;
    } item_t;

    typedef struct packed {
        logic   start;
        fp_op_t op;
    } fpu_ctrl_t;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++)
        begin
            if (v[i])
            begin
                n = 5'(23 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        n = 5'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (v[i])
            begin
                n = 5'(26 - i);
            end
        end
        return n;
    endfunction

    // sig holds 1.f at bit 26 with guard, round and sticky below; e is biased.
    function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                               input logic [26:0] sig);
        logic signed [11:0] ee;
        logic [26:0]        sg;
        logic [26:0]        mask;
        logic [4:0]         sh;
        logic               up;
        logic [24:0]        mant;
        logic [7:0]         ef;
        logic [22:0]        fr;
        ee = e;
        sg = sig;
        if (ee >= 12'sd255)
        begin
            return {s, 8'hFF, 23'd0};
        end
        if (ee <= 12'sd0)
        begin
            if (ee < -12'sd25)
            begin
                sh = 5'd27;
            end
            else
            begin
                sh = 5'(12'sd1 - ee);
            end
            mask = (27'd1 << sh) - 27'd1;
            sg   = (sg >> sh) | {26'd0, |(sig & mask)};
            ee   = 12'sd0;
        end
        up   = sg[2] & (sg[1] | sg[0] | sg[3]);
        mant = {1'b0, sg[26:3]} + {24'd0, up};
        if (ee == 12'sd0)
        begin
            ef = {7'd0, mant[23]};
        end
        else
        begin
            ef = 8'(ee) + {7'd0, mant[24]};
        end
        fr = mant[24] ? 23'd0 : mant[22:0];
        return {s, ef, fr};
    endfunction

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [3:0]  p;
        logic [3:0]  k;
        logic [10:0] t;
        p = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (h[i])
            begin
                p = 4'(i);
            end
        end
        k = 4'd10 - p;
        t = {1'b0, h[9:0]} << k;
        if (h[14:10] == 5'd31)
        begin
            return {h[15], 8'hFF, h[9:0], 13'd0};
        end
        if (h[14:10] == 5'd0)
        begin
            if (h[9:0] == 10'd0)
            begin
                return {h[15], 31'd0};
            end
            return {h[15], 8'd113 - {4'd0, k}, t[9:0], 13'd0};
        end
        return {h[15], {3'd0, h[14:10]} + 8'd112, h[9:0], 13'd0};
    endfunction

    // Clamp to +/-65504 (NaN gives a quiet NaN), round to nearest with ties away from zero.
    function automatic logic [15:0] narrow_half(input logic [31:0] f);
        logic        s;
        logic [7:0]  e;
        logic [22:0] m;
        logic [15:0] r;
        logic [24:0] sig;
        logic [6:0]  sh;
        logic [24:0] rnd;
        s = f[31];
        e = f[30:23];
        m = f[22:0];
        if (e == 8'd255)
        begin
            return (m != 23'd0) ? {s, HALF_QNAN_MAG} : {s, HALF_MAX_MAG};
        end
        if (e >= 8'd143)
        begin
            return {s, HALF_MAX_MAG};
        end
        if (e >= 8'd113)
        begin
            r = {1'b0, 5'(e - 8'd112), m[22:13]} + {15'd0, m[12]};
            if (r > {1'b0, HALF_MAX_MAG})
            begin
                r = {1'b0, HALF_MAX_MAG};
            end
            return {s, r[14:0]};
        end
        if (e == 8'd0)
        begin
            return {s, 15'd0};
        end
        sh = 7'(8'd126 - e);
        if (sh > 7'd24)
        begin
            return {s, 15'd0};
        end
        sig = {2'b01, m};
        rnd = (sig + (25'd1 << (sh - 7'd1))) >> sh;
        return {s, rnd[14:0]};
    endfunction

endpackage

`default_nettype wire

[design/sampled_dot_product_scale.sv]
// ============================================================================
// sampled_dot_product_scale
// fp32/fp16 sampled dot product with alpha/beta output scaling.
// ============================================================================
// Items are taken into a two-entry queue and worked off by one shared
// three-stage fp32 multiply/add unit, one operation at a time. An item that
// does not end a run is dequeued, multiplied and accumulated. The last item
// of a run adds the alpha multiply, with nonzero beta also the beta multiply
// and the final add, and then loads the output register. Results are fp32
// rounded to nearest even; in half mode operands are fp16 and the result is
// saturated to +/-65504 and rounded to fp16 in bits 15..0.
// ============================================================================
`default_nettype none

module sampled_dot_product_scale
    import sdps_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [31:0]            x_element,
    input  wire logic [31:0]            y_element,
    input  wire logic [31:0]            old_value,
    input  wire logic                   last_element,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [31:0]                 result_value
);

    logic [31:0] alpha_reg;
    logic [31:0] beta_reg;
    logic        half_reg;
    logic        q_valid;
    item_t       q_item;
    logic        q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            beta_reg  <= FP_ZERO;
            half_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ALPHA: alpha_reg <= cfg_data;
                REG_BETA:  beta_reg  <= cfg_data;
                REG_HALF:  half_reg  <= cfg_data[0];
                default:   half_reg  <= half_reg;
            endcase
        end
    end

    sdps_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .x_element    (x_element),
        .y_element    (y_element),
        .old_value    (old_value),
        .last_element (last_element),
        .half_mode    (half_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    sdps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .alpha        (alpha_reg),
        .beta         (beta_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value)
    );

endmodule

`default_nettype wire

[design/sdps_front.sv]
// ============================================================================
// sdps_front
// Accepts items, decodes operands under the current mode, queues them.
// ============================================================================
`default_nettype none

module sdps_front
    import sdps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] x_element,
    input  wire logic [31:0] y_element,
    input  wire logic [31:0] old_value,
    input  wire logic        last_element,
    input  wire logic        half_mode,
    output logic             q_valid,
    output item_t            q_item,
    input  wire logic        q_pop
);

    item_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   push;
    logic                   pop;
    item_t                  dec;

    assign in_stall = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        dec.x    = half_mode ? widen_half(x_element[15:0]) : x_element;
        dec.y    = half_mode ? widen_half(y_element[15:0]) : y_element;
        dec.old  = half_mode ? widen_half(old_value[15:0]) : old_value;
        dec.last = last_element;
        dec.half = half_mode;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

[design/sdps_fpu.sv]
// ============================================================================
// sdps_fpu
// Three-stage fp32 multiply / add unit, round to nearest even; the caller keeps one op in flight.
// ============================================================================
`default_nettype none

module sdps_fpu
    import sdps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire fpu_ctrl_t   ctrl,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic             done,
    output logic [31:0]      result
);

    // stage 1: unpack, specials, prenormalize (mul) or align (add)
    logic               v1_reg;
    fp_op_t             op1_reg;
    logic               spec1_reg;
    logic [31:0]        sval1_reg;
    logic               s1_reg;
    logic               sub1_reg;
    logic signed [11:0] e1_reg;
    logic [26:0]        pa1_reg;
    logic [26:0]        pb1_reg;
    // stage 2: multiply or add
    logic               v2_reg;
    fp_op_t             op2_reg;
    logic               spec2_reg;
    logic [31:0]        sval2_reg;
    logic               s2_reg;
    logic signed [11:0] e2_reg;
    logic [47:0]        acc2_reg;
    // stage 3: normalize and round
    logic               done_reg;
    logic [31:0]        result_reg;

    logic               spec1_next;
    logic [31:0]        sval1_next;
    logic               s1_next;
    logic               sub1_next;
    logic signed [11:0] e1_next;
    logic [26:0]        pa1_next;
    logic [26:0]        pb1_next;
    logic [47:0]        acc2_next;
    logic [31:0]        result_next;

    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [23:0] ma, mb;
    logic [4:0]  lza, lzb;
    logic signed [11:0] ea, eb;
    logic        swap;
    logic [31:0] big, sml;
    logic [7:0]  el, es, d;
    logic [4:0]  sh;
    logic [26:0] bfull, mask;
    logic [27:0] sum;
    logic [4:0]  lzs;
    logic [26:0] sig;
    logic signed [11:0] en;

    assign nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    assign nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    assign inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    assign inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    assign zero_a = (a[30:0] == 31'd0);
    assign zero_b = (b[30:0] == 31'd0);

    always_comb
    begin
        ma  = {|a[30:23], a[22:0]};
        mb  = {|b[30:23], b[22:0]};
        lza = (a[30:23] == 8'd0) ? lzc24(ma) : 5'd0;
        lzb = (b[30:23] == 8'd0) ? lzc24(mb) : 5'd0;
        ea  = (a[30:23] == 8'd0) ? 12'sd1 - $signed({7'd0, lza}) : $signed({4'd0, a[30:23]});
        eb  = (b[30:23] == 8'd0) ? 12'sd1 - $signed({7'd0, lzb}) : $signed({4'd0, b[30:23]});

        swap  = (a[30:0] < b[30:0]);
        big   = swap ? b : a;
        sml   = swap ? a : b;
        el    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d     = el - es;
        sh    = (d > 8'd27) ? 5'd27 : d[4:0];
        bfull = {|sml[30:23], sml[22:0], 3'b000};
        mask  = (27'd1 << sh) - 27'd1;

        spec1_next = 1'b0;
        sval1_next = FP_ZERO;
        if (ctrl.op == FP_MUL)
        begin
            s1_next   = a[31] ^ b[31];
            sub1_next = 1'b0;
            e1_next   = ea + eb - 12'sd127;
            pa1_next  = {3'd0, ma << lza};
            pb1_next  = {3'd0, mb << lzb};
            if (nan_a)
            begin
                spec1_next = 1'b1;
                sval1_next = a | FP_QUIET_BIT;
            end
            else if (nan_b)
            begin
                spec1_next = 1'b1;
                sval1_next = b | FP_QUIET_BIT;
            end
            else if ((inf_a && zero_b) || (inf_b && zero_a))
            begin
                spec1_next = 1'b1;
                sval1_next = FP_NAN_INVAL;
            end
            else if (inf_a || inf_b)
            begin
                spec1_next = 1'b1;
                sval1_next = {s1_next, 8'hFF, 23'd0};
            end
            else if (zero_a || zero_b)
            begin
                spec1_next = 1'b1;
                sval1_next = {s1_next, 31'd0};
            end
        end
        else
        begin
            s1_next   = big[31];
            sub1_next = a[31] ^ b[31];
            e1_next   = $signed({4'd0, el});
            pa1_next  = {|big[30:23], big[22:0], 3'b000};
            pb1_next  = (bfull >> sh) | {26'd0, |(bfull & mask)};
            if (nan_a)
            begin
                spec1_next = 1'b1;
                sval1_next = a | FP_QUIET_BIT;
            end
            else if (nan_b)
            begin
                spec1_next = 1'b1;
                sval1_next = b | FP_QUIET_BIT;
            end
            else if (inf_a && inf_b && (a[31] != b[31]))
            begin
                spec1_next = 1'b1;
                sval1_next = FP_NAN_INVAL;
            end
            else if (inf_a)
            begin
                spec1_next = 1'b1;
                sval1_next = a;
            end
            else if (inf_b)
            begin
                spec1_next = 1'b1;
                sval1_next = b;
            end
            else if (zero_a && zero_b)
            begin
                spec1_next = 1'b1;
                sval1_next = {a[31] & b[31], 31'd0};
            end
        end
    end

    always_comb
    begin
        if (op1_reg == FP_MUL)
        begin
            acc2_next = pa1_reg[23:0] * pb1_reg[23:0];
        end
        else if (sub1_reg)
        begin
            acc2_next = {20'd0, {1'b0, pa1_reg} - {1'b0, pb1_reg}};
        end
        else
        begin
            acc2_next = {20'd0, {1'b0, pa1_reg} + {1'b0, pb1_reg}};
        end
    end

    always_comb
    begin
        sum = acc2_reg[27:0];
        lzs = lzc27(sum[26:0]);
        if (op2_reg == FP_MUL)
        begin
            if (acc2_reg[47])
            begin
                sig = acc2_reg[47:21] | {26'd0, |acc2_reg[20:0]};
                en  = e2_reg + 12'sd1;
            end
            else
            begin
                sig = acc2_reg[46:20] | {26'd0, |acc2_reg[19:0]};
                en  = e2_reg;
            end
        end
        else if (sum[27])
        begin
            sig = sum[27:1] | {26'd0, sum[0]};
            en  = e2_reg + 12'sd1;
        end
        else
        begin
            sig = sum[26:0] << lzs;
            en  = e2_reg - $signed({7'd0, lzs});
        end

        if (spec2_reg)
        begin
            result_next = sval2_reg;
        end
        else if ((op2_reg == FP_ADD) && (sum == 28'd0))
        begin
            result_next = FP_ZERO;
        end
        else
        begin
            result_next = round_pack(s2_reg, en, sig);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= ctrl.start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            op1_reg   <= ctrl.op;
            spec1_reg <= spec1_next;
            sval1_reg <= sval1_next;
            s1_reg    <= s1_next;
            sub1_reg  <= sub1_next;
            e1_reg    <= e1_next;
            pa1_reg   <= pa1_next;
            pb1_reg   <= pb1_next;
        end
        if (v1_reg)
        begin
            op2_reg   <= op1_reg;
            spec2_reg <= spec1_reg;
            sval2_reg <= sval1_reg;
            s2_reg    <= s1_reg;
            e2_reg    <= e1_reg;
            acc2_reg  <= acc2_next;
        end
        if (v2_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[design/sdps_back.sv]
// ============================================================================
// sdps_back
// Sequences the multiply/accumulate and final scaling of queued items.
// ============================================================================
`default_nettype none

module sdps_back
    import sdps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire item_t       q_item,
    output logic             q_pop,
    input  wire logic [31:0] alpha,
    input  wire logic [31:0] beta,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      result_value
);

    back_state_t state_reg;
    back_state_t state_next;
    item_t       cur_reg;
    logic [31:0] acc_reg;
    logic [31:0] r_reg;
    logic [31:0] c_reg;
    logic        wait_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    fpu_ctrl_t   fctrl;
    logic [31:0] fa;
    logic [31:0] fb;
    logic        fdone;
    logic [31:0] fres;
    logic        op_state;
    logic        beta_nz;
    logic        slot_free;

    assign beta_nz   = (beta[30:0] != 31'd0);
    assign slot_free = !out_valid_reg || !out_stall;

    sdps_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (fctrl),
        .a      (fa),
        .b      (fb),
        .done   (fdone),
        .result (fres)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (q_valid) state_next = ST_MUL_XY;
            ST_MUL_XY:    if (fdone) state_next = ST_ADD_ACC;
            ST_ADD_ACC:   if (fdone) state_next = cur_reg.last ? ST_MUL_ALPHA : ST_IDLE;
            ST_MUL_ALPHA: if (fdone) state_next = beta_nz ? ST_MUL_BETA : ST_OUT;
            ST_MUL_BETA:  if (fdone) state_next = ST_ADD_C;
            ST_ADD_C:     if (fdone) state_next = ST_OUT;
            ST_OUT:       if (slot_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        op_state = 1'b0;
        fctrl.op = FP_MUL;
        fa       = cur_reg.x;
        fb       = cur_reg.y;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop = q_valid;
            end
            ST_MUL_XY:
            begin
                op_state = 1'b1;
            end
            ST_ADD_ACC:
            begin
                op_state = 1'b1;
                fctrl.op = FP_ADD;
                fa       = acc_reg;
                fb       = r_reg;
            end
            ST_MUL_ALPHA:
            begin
                op_state = 1'b1;
                fa       = alpha;
                fb       = acc_reg;
            end
            ST_MUL_BETA:
            begin
                op_state = 1'b1;
                fa       = beta;
                fb       = cur_reg.old;
            end
            ST_ADD_C:
            begin
                op_state = 1'b1;
                fctrl.op = FP_ADD;
                fa       = r_reg;
                fb       = c_reg;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
        fctrl.start = op_state && !wait_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= FP_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            if (fctrl.start)
            begin
                wait_reg <= 1'b1;
            end
            else if (fdone)
            begin
                wait_reg <= 1'b0;
            end
            if ((state_reg == ST_OUT) && slot_free)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= FP_ZERO;
            end
            else
            begin
                if (!out_stall)
                begin
                    out_valid_reg <= 1'b0;
                end
                if ((state_reg == ST_ADD_ACC) && fdone)
                begin
                    acc_reg <= fres;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        if (fdone && ((state_reg == ST_MUL_XY) || (state_reg == ST_MUL_ALPHA)
                      || (state_reg == ST_ADD_C)))
        begin
            r_reg <= fres;
        end
        if (fdone && (state_reg == ST_MUL_BETA))
        begin
            c_reg <= fres;
        end
        if ((state_reg == ST_OUT) && slot_free)
        begin
            out_data_reg <= cur_reg.half ? {16'd0, narrow_half(r_reg)} : r_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_data_reg;

endmodule

`default_nettype wire

[design/sdps_checker.sv]
// ============================================================================
// sdps_checker
// Port-level checks on results, attached to the top level by bind.
// ============================================================================
`default_nettype none

module sdps_checker
    import sdps_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   cfg_write,
    input wire logic [CFG_INDEX_W-1:0] cfg_index,
    input wire logic [31:0]            cfg_data,
    input wire logic                   in_valid,
    input wire logic                   in_stall,
    input wire logic [31:0]            x_element,
    input wire logic [31:0]            y_element,
    input wire logic [31:0]            old_value,
    input wire logic                   last_element,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic [31:0]            result_value
);

    logic half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= 1'b0;
        end
        else if (cfg_write && (cfg_index == REG_HALF))
        begin
            half_reg <= cfg_data[0];
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value))
        else $error("stalled item changed or dropped");

    a_half_upper: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && half_reg |-> result_value[31:16] == 16'd0)
        else $error("half result has upper bits set");

    a_half_no_inf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && half_reg |-> result_value[14:0] != HALF_INF_MAG)
        else $error("half result not saturated");

endmodule

bind sampled_dot_product_scale sdps_checker u_sdps_checker (.*);

`default_nettype wire

[dv/tb_sampled_dot_product_scale.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sampled_dot_product_scale
// Drives runs of x/y element pairs into the sampled dot product block and
// checks each scaled result against a bit-exact fp32/fp16 model kept in the
// bench or the expected value of a directed row. The directed table comes
// first, then random runs across several alpha/beta/mode settings and handshake idle patterns.
// ----------------------------------------------------------------------------
module tb_sampled_dot_product_scale;
    import sdps_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(3);
    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 125;

    typedef struct {
        bit                   wr;
        logic [CFG_INDEX_W-1:0] idx;
        logic [31:0]          data;
        logic [31:0]          x;
        logic [31:0]          y;
        logic [31:0]          old;
        bit                   last;
        bit                   typed;
        logic [31:0]          expv;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [31:0]            x_element;
    logic [31:0]            y_element;
    logic [31:0]            old_value;
    logic                   last_element;
    logic                   out_valid;
    logic                   out_stall;
    logic [31:0]            result_value;

    logic [31:0] alpha_q;
    logic [31:0] beta_q;
    logic        half_q;
    logic [31:0] acc_q;
    logic [31:0] expected_results[$];
    row_t        dir_rows[$];

    int errors;
    int items_sent;
    int results_seen;
    int tx_pct;
    int rx_pct;
    int hold_left;
    int quiet_cycles;

    sampled_dot_product_scale u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .x_element    (x_element),
        .y_element    (y_element),
        .old_value    (old_value),
        .last_element (last_element),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // value = mag * 2^e, rounded to nearest even into fp32
    function automatic logic [31:0] fp_round(input logic s, input int e, input logic [127:0] mag);
        int           p;
        int           bexp;
        int           sh;
        logic [127:0] keep;
        logic [127:0] low;
        logic         guard;
        logic         sticky;
        if (mag == 128'd0)
        begin
            return {s, 31'd0};
        end
        p = 0;
        for (int i = 0; i < 128; i++)
        begin
            if (mag[i])
            begin
                p = i;
            end
        end
        bexp = p + e + 127;
        sh = (bexp >= 1) ? p - 23 : -149 - e;
        guard = 1'b0;
        sticky = 1'b0;
        if (sh >= 128)
        begin
            keep = 128'd0;
            sticky = 1'b1;
        end
        else if (sh > 0)
        begin
            keep = mag >> sh;
            guard = mag[sh-1];
            low = mag & ((128'd1 << (sh - 1)) - 128'd1);
            sticky = (low != 128'd0);
        end
        else
        begin
            keep = mag << (-sh);
        end
        if (guard && (sticky || keep[0]))
        begin
            keep = keep + 128'd1;
        end
        if (bexp >= 1)
        begin
            if (keep == (128'd1 << 24))
            begin
                keep = keep >> 1;
                bexp = bexp + 1;
            end
            if (bexp >= 255)
            begin
                return {s, 8'hFF, 23'd0};
            end
            return {s, 8'(bexp), keep[22:0]};
        end
        return {s, keep[30:0]};
    endfunction

    function automatic bit is_nan(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    function automatic bit is_inf(input logic [31:0] f);
        return f[30:0] == 31'h7F80_0000;
    endfunction

    function automatic logic [23:0] sig_of(input logic [31:0] f);
        return (f[30:23] == 8'd0) ? {1'b0, f[22:0]} : {1'b1, f[22:0]};
    endfunction

    function automatic int exp_of(input logic [31:0] f);
        return (f[30:23] == 8'd0) ? -149 : int'(f[30:23]) - 150;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic         s;
        logic [127:0] mag;
        if (is_nan(a))
        begin
            return a | FP_QUIET_BIT;
        end
        if (is_nan(b))
        begin
            return b | FP_QUIET_BIT;
        end
        s = a[31] ^ b[31];
        if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
        begin
            return QNAN_DEFAULT;
        end
        if (is_inf(a) || is_inf(b))
        begin
            return {s, 8'hFF, 23'd0};
        end
        mag = 128'(sig_of(a)) * 128'(sig_of(b));
        return fp_round(s, exp_of(a) + exp_of(b), mag);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]  hi;
        logic [31:0]  lo;
        logic [127:0] mh;
        logic [127:0] ml;
        logic [127:0] mag;
        logic         s;
        int           d;
        int           e;
        if (is_nan(a))
        begin
            return a | FP_QUIET_BIT;
        end
        if (is_nan(b))
        begin
            return b | FP_QUIET_BIT;
        end
        if (is_inf(a) && is_inf(b) && (a[31] != b[31]))
        begin
            return QNAN_DEFAULT;
        end
        if (is_inf(a))
        begin
            return a;
        end
        if (is_inf(b))
        begin
            return b;
        end
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
        begin
            return {a[31] & b[31], 31'd0};
        end
        if (a[30:0] == 31'd0)
        begin
            return b;
        end
        if (b[30:0] == 31'd0)
        begin
            return a;
        end
        if (exp_of(a) >= exp_of(b))
        begin
            hi = a;
            lo = b;
        end
        else
        begin
            hi = b;
            lo = a;
        end
        d = exp_of(hi) - exp_of(lo);
        if (d > 60)
        begin
            // far smaller operand only acts as a sticky bit
            mh = 128'(sig_of(hi)) << 60;
            ml = 128'd1;
            e = exp_of(hi) - 60;
        end
        else
        begin
            mh = 128'(sig_of(hi)) << d;
            ml = 128'(sig_of(lo));
            e = exp_of(lo);
        end
        if (hi[31] == lo[31])
        begin
            mag = mh + ml;
            s = hi[31];
        end
        else if (mh >= ml)
        begin
            mag = mh - ml;
            s = hi[31];
        end
        else
        begin
            mag = ml - mh;
            s = lo[31];
        end
        if (mag == 128'd0)
        begin
            return 32'd0;
        end
        return fp_round(s, e, mag);
    endfunction

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [31:0] ex;
        logic [9:0]  m;
        logic [10:0] w;
        m = h[9:0];
        if (h[14:10] == 5'd31)
        begin
            return {h[15], 8'hFF, m, 13'd0};
        end
        if (h[14:10] != 5'd0)
        begin
            return {h[15], 8'(h[14:10]) + 8'd112, m, 13'd0};
        end
        if (m == 10'd0)
        begin
            return {h[15], 31'd0};
        end
        ex = 113;
        w = {1'b0, m};
        while (!w[10])
        begin
            w = w << 1;
            ex = ex - 1;
        end
        return {h[15], ex[7:0], w[9:0], 13'd0};
    endfunction

    function automatic logic [15:0] single_to_half(input logic [31:0] f);
        logic [15:0] s;
        logic [31:0] e;
        logic [31:0] m;
        logic [31:0] r;
        logic [31:0] sh;
        s = {f[31], 15'd0};
        e = 32'(f[30:23]);
        m = 32'(f[22:0]);
        if (e == 255)
        begin
            return (m != 0) ? (s | 16'h7E00) : (s | 16'h7BFF);
        end
        if (e >= 143)
        begin
            return s | 16'h7BFF;
        end
        if (e >= 113)
        begin
            r = (((e - 112) << 10) | (m >> 13)) + ((m >> 12) & 1);
            if (r > 32'h7BFF)
            begin
                r = 32'h7BFF;
            end
            return s | r[15:0];
        end
        if (e == 0)
        begin
            return s;
        end
        sh = 126 - e;
        if (sh > 24)
        begin
            return s;
        end
        r = ((m | 32'h0080_0000) + (32'd1 << (sh - 1))) >> sh;
        return s | r[15:0];
    endfunction

    function automatic logic [31:0] decode_operand(input logic [31:0] raw);
        return half_q ? half_to_single(raw[15:0]) : raw;
    endfunction

    // Advances the dot product by one item; returns 1 with the scaled value on last.
    function automatic bit dot_scale_step(input logic [31:0] x, input logic [31:0] y,
                                          input logic [31:0] old, input logic last,
                                          output logic [31:0] scaled);
        logic [31:0] sum;
        logic [31:0] res;
        sum = fp_add(acc_q, fp_mul(decode_operand(x), decode_operand(y)));
        acc_q = sum;
        scaled = 32'd0;
        if (!last)
        begin
            return 1'b0;
        end
        res = fp_mul(alpha_q, sum);
        if (beta_q[30:0] != 31'd0)
        begin
            res = fp_add(res, fp_mul(beta_q, decode_operand(old)));
        end
        scaled = half_q ? {16'd0, single_to_half(res)} : res;
        acc_q = 32'd0;
        return 1'b1;
    endfunction

    task automatic send_item(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] old, input logic last,
                             input bit typed, input logic [31:0] expv);
        logic [31:0] scaled;
        while ($urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        x_element <= x;
        y_element <= y;
        old_value <= old;
        last_element <= last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
        if (dot_scale_step(x, y, old, last, scaled))
        begin
            expected_results.push_back(typed ? expv : scaled);
        end
        @(negedge clk);
    endtask

    task automatic settle;
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_ALPHA: alpha_q = data;
            REG_BETA:  beta_q = data;
            REG_HALF:  half_q = data[0];
            default:   ;
        endcase
    endtask

    function automatic row_t item_row(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] old, input bit last,
                                      input bit typed, input logic [31:0] expv);
        row_t r;
        r = '{default: '0};
        r.x = x;
        r.y = y;
        r.old = old;
        r.last = last;
        r.typed = typed;
        r.expv = expv;
        return r;
    endfunction

    function automatic row_t wr_row(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        row_t r;
        r = '{default: '0};
        r.wr = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic logic [31:0] random_operand(input bit half);
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(99) < 15)
        begin
            return r;
        end
        if (half)
        begin
            r[14:10] = 5'($urandom_range(25, 5));
        end
        else
        begin
            r[30:23] = 8'($urandom_range(144, 110));
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_alpha;
        case ($urandom_range(4))
            0: return ALPHA_RESET;
            1: return FP_ZERO;
            2: return 32'h7F7F_FFFF;
            3: return 32'h8000_0001;
            default: return random_operand(1'b0);
        endcase
    endfunction

    function automatic logic [31:0] pick_beta;
        case ($urandom_range(3))
            0: return FP_ZERO;
            1: return 32'h8000_0000;
            2: return 32'h3F80_0000;
            default: return random_operand(1'b0);
        endcase
    endfunction

    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        rx_pct = 0;
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h", $time, result_value);
                errors++;
            end
            else
            begin
                if (result_value !== expected_results[0])
                begin
                    $display("%0t result_value mismatch: expected %h actual %h",
                             $time, expected_results[0], result_value);
                    errors++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_sampled_dot_product_scale: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [31:0] run_left;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        tx_pct = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_ALPHA;
        cfg_data = 32'd0;
        in_valid = 1'b0;
        x_element = 32'd0;
        y_element = 32'd0;
        old_value = 32'd0;
        last_element = 1'b0;
        alpha_q = ALPHA_RESET;
        beta_q = FP_ZERO;
        half_q = 1'b0;
        acc_q = FP_ZERO;

        dir_rows.push_back(item_row(32'h3F80_0000, 32'h4000_0000, 0, 1, 1, 32'h4000_0000));
        dir_rows.push_back(item_row(32'h0000_0000, 32'h0000_0000, 0, 1, 1, 32'h0000_0000));
        dir_rows.push_back(item_row(32'h7F80_0000, 32'h0000_0000, 0, 1, 1, QNAN_DEFAULT));
        dir_rows.push_back(item_row(32'h7F7F_FFFF, 32'h7F7F_FFFF, 0, 1, 1, 32'h7F80_0000));
        dir_rows.push_back(item_row(32'h0000_0001, 32'h3F00_0000, 0, 1, 1, 32'h0000_0000));
        dir_rows.push_back(item_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0));
        dir_rows.push_back(item_row(32'h4040_0000, 32'h4040_0000, 0, 0, 0, 0));
        dir_rows.push_back(item_row(32'h3F80_0000, 32'hBF80_0000, 0, 1, 1, 32'h4100_0000));
        dir_rows.push_back(wr_row(REG_BETA, 32'h3F80_0000));
        dir_rows.push_back(item_row(32'h3F80_0000, 32'h3F80_0000, 32'h4000_0000, 1, 1,
                                    32'h4040_0000));
        dir_rows.push_back(wr_row(REG_BETA, 32'h8000_0000));
        dir_rows.push_back(item_row(32'h3F80_0000, 32'h3F80_0000, 32'h7FC0_0000, 1, 1,
                                    32'h3F80_0000));
        dir_rows.push_back(wr_row(REG_HALF, 32'hFFFF_FFFF));
        dir_rows.push_back(item_row(32'hFFFF_3C00, 32'hABCD_4000, 32'hFFFF_FFFF, 1, 1,
                                    32'h0000_4000));
        dir_rows.push_back(item_row(32'h0000_7BFF, 32'h0000_7BFF, 0, 1, 1, 32'h0000_7BFF));
        dir_rows.push_back(item_row(32'h0000_7C00, 32'h0000_3C00, 0, 1, 1, 32'h0000_7BFF));
        dir_rows.push_back(item_row(32'h0000_FC00, 32'h0000_0000, 0, 1, 1, 32'h0000_FE00));
        dir_rows.push_back(item_row(32'h0000_0001, 32'h0000_0001, 0, 1, 1, 32'h0000_0000));
        dir_rows.push_back(item_row(32'h0000_3C00, 32'h0000_3C00, 0, 0, 0, 0));
        dir_rows.push_back(wr_row(REG_HALF, 32'h0000_0000));
        dir_rows.push_back(item_row(32'h3F80_0000, 32'h3F80_0000, 0, 1, 1, 32'h4000_0000));
        dir_rows.push_back(wr_row(REG_ALPHA, 32'h4000_0000));
        dir_rows.push_back(wr_row(REG_UNUSED, 32'hFFFF_FFFF));
        dir_rows.push_back(item_row(32'h3F80_0000, 32'h3FC0_0000, 0, 1, 1, 32'h4040_0000));

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].wr)
            begin
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            else
            begin
                send_item(dir_rows[i].x, dir_rows[i].y, dir_rows[i].old, dir_rows[i].last,
                          dir_rows[i].typed, dir_rows[i].expv);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_ALPHA, pick_alpha());
            write_reg(REG_BETA, pick_beta());
            write_reg(REG_HALF, 32'(p[0] ^ p[2]));
            case (p % 4)
                0: begin tx_pct = 0;  rx_pct = 0;  end
                1: begin tx_pct = 49; rx_pct = 0;  end
                2: begin tx_pct = 0;  rx_pct = 49; end
                default: begin tx_pct = 23; rx_pct = 23; end
            endcase
            if (p == 4)
            begin
                hold_left = 300;
            end
            run_left = $urandom_range(8, 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                run_left--;
                send_item(random_operand(half_q), random_operand(half_q),
                          random_operand(half_q), (run_left == 0) || (n == ITEMS_PER_PHASE - 1),
                          0, 0);
                if (run_left == 0 || n == ITEMS_PER_PHASE - 1)
                begin
                    run_left = $urandom_range(8, 1);
                end
            end
        end

        tx_pct = 0;
        rx_pct = 0;
        settle();
        $display("covered %0d items and %0d results: directed table plus %0d random phases",
                 items_sent, results_seen, PHASES);
        $display("fp32/fp16 modes, alpha/beta extremes, idle and long stall patterns exercised");
        if (errors == 0)
        begin
            $display("tb_sampled_dot_product_scale: done, clean");
        end
        else
        begin
            $display("tb_sampled_dot_product_scale: done, errors");
        end
        $finish;
    end

endmodule

[sampled_dot_product_scale.f]
design/sdps_pkg.sv
design/sdps_front.sv
design/sdps_fpu.sv
design/sdps_back.sv
design/sampled_dot_product_scale.sv
design/sdps_checker.sv
dv/tb_sampled_dot_product_scale.sv
